// ----- hdl/dsip_pkg.sv -----
// Shared types and constants for the disk set intersection pruner.
// Used by dsip_ctrl, dsip_dp and disk_set_intersection_pruner_top; no dependencies.
`default_nettype none

package dsip_pkg;

  // Default sizing of the disk store.
  localparam int MAX_DISKS_DEF = 64;
  localparam int MAX_DIM_DEF   = 4;

  // Fixed field widths.
  localparam int COORD_W     = 16;
  localparam int RADIUS_W    = 16;
  localparam int LABEL_W     = 20;
  localparam int COUNT_OUT_W = 7;
  localparam int NUM_COORDS  = 4;
  localparam int SQ_W        = 32;
  localparam int D2_W        = 34;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int DIM_W      = 3;
  localparam logic [DIM_W-1:0] DIM_RESET = 3'd2;
  localparam logic CFG_IDX_DIMENSION = 1'b0;

  // Item modes.
  typedef enum logic [1:0] {
    MODE_INIT   = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_UPDATE = 2'd2,
    MODE_CLEAN  = 2'd3
  } dsip_mode_t;

  // One input beat.
  typedef struct packed {
    dsip_mode_t                 mode;
    logic signed [COORD_W-1:0]  coord_0;
    logic signed [COORD_W-1:0]  coord_1;
    logic signed [COORD_W-1:0]  coord_2;
    logic signed [COORD_W-1:0]  coord_3;
    logic [RADIUS_W-1:0]        radius;
    logic [LABEL_W-1:0]         label;
  } dsip_in_t;

  // One result beat.
  typedef struct packed {
    logic                   is_empty;
    logic [COUNT_OUT_W-1:0] disk_count;
    logic [LABEL_W-1:0]     stored_label;
    logic                   overflow;
  } dsip_out_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_EXEC  = 3'd1,
    ST_WALK  = 3'd2,
    ST_DRAIN = 3'd3,
    ST_DONE  = 3'd4
  } dsip_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic exec;
    logic issue;
    logic commit;
    logic load_out;
  } dsip_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic walk_req;
    logic last_issue;
    logic pipe_empty;
    logic out_free;
  } dsip_sts_t;

endpackage

`default_nettype wire

// ----- hdl/disk_set_intersection_pruner_top.sv -----
// Top level of the disk set intersection pruner: configuration register and
// the controller / datapath pair. Depends on dsip_pkg, dsip_ctrl and dsip_dp.
//
// Usage:
//   Items arrive on the in_ channel (valid/ready) as a dsip_in_t beat; each
//   item gives exactly one dsip_out_t beat on the out_ channel.
//   The cfg_ port is an APB-style slave with one register, dimension, at
//   byte address 0; writes are expected only while the block is idle.
//   Initialize, append, clean, and update on an empty set go from acceptance
//   through the EXEC and DONE states to the result beat. An update on a set
//   of N disks reads the store one entry per cycle through a three-stage
//   compare pipeline, then drains it and commits the new disk count.
//   One item is worked on at a time; in_ready is high only while idle.
//   The result register lets a new item be accepted while the previous
//   result beat still waits; if the receiver stalls, the next result waits
//   in the controller until the register is free.
//   Reset clears the disk count, empty flag, label and overflow, and sets
//   dimension to 2. The disk store itself is not cleared.
`default_nettype none

module disk_set_intersection_pruner_top #(
  parameter int MAX_DISKS = dsip_pkg::MAX_DISKS_DEF,
  parameter int MAX_DIM   = dsip_pkg::MAX_DIM_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire dsip_pkg::dsip_in_t              in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output dsip_pkg::dsip_out_t                  out_data,
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [dsip_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [dsip_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [dsip_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                 cfg_pready
);

  logic [dsip_pkg::DIM_W-1:0] dim_r;
  logic                       cfg_sel_dim;
  dsip_pkg::dsip_cmd_t        cmd;
  dsip_pkg::dsip_sts_t        sts;

  assign cfg_pready  = 1'b1;
  assign cfg_sel_dim = (cfg_paddr[2] == dsip_pkg::CFG_IDX_DIMENSION);

  // Dimension register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r <= dsip_pkg::DIM_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_sel_dim) begin
      dim_r <= cfg_pwdata[dsip_pkg::DIM_W-1:0];
    end
  end

  // Read-back.
  assign cfg_prdata = cfg_sel_dim ? dsip_pkg::CFG_DATA_W'(dim_r) : '0;

  dsip_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dsip_dp #(
    .MAX_DISKS (MAX_DISKS),
    .MAX_DIM   (MAX_DIM)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .dimension (dim_r),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ----- hdl/dsip_ctrl.sv -----
// Controller state machine of the disk set intersection pruner.
// Depends on dsip_pkg for the state, command and status types.
`default_nettype none

module dsip_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire dsip_pkg::dsip_sts_t sts,
  output dsip_pkg::dsip_cmd_t  cmd
);

  dsip_pkg::dsip_state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dsip_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      dsip_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = sts.walk_req ? dsip_pkg::ST_WALK : dsip_pkg::ST_EXEC;
        end
      end
      dsip_pkg::ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = dsip_pkg::ST_DONE;
      end
      dsip_pkg::ST_WALK: begin
        cmd.issue = 1'b1;
        if (sts.last_issue) begin
          state_nxt = dsip_pkg::ST_DRAIN;
        end
      end
      dsip_pkg::ST_DRAIN: begin
        if (sts.pipe_empty) begin
          cmd.commit = 1'b1;
          state_nxt  = dsip_pkg::ST_DONE;
        end
      end
      dsip_pkg::ST_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = dsip_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = dsip_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/dsip_dp.sv -----
// Datapath of the disk set intersection pruner: disk store, compare pipeline,
// counters and result register. Depends on dsip_pkg.
`default_nettype none

module dsip_dp #(
  parameter int MAX_DISKS = dsip_pkg::MAX_DISKS_DEF,
  parameter int MAX_DIM   = dsip_pkg::MAX_DIM_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire dsip_pkg::dsip_in_t         in_data,
  input  wire logic [dsip_pkg::DIM_W-1:0] dimension,
  input  wire dsip_pkg::dsip_cmd_t        cmd,
  output dsip_pkg::dsip_sts_t             sts,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output dsip_pkg::dsip_out_t             out_data
);

  localparam int CW   = $clog2(MAX_DISKS + 1);
  localparam int AW   = (MAX_DISKS > 1) ? $clog2(MAX_DISKS) : 1;
  localparam int CEN_W = MAX_DIM * dsip_pkg::COORD_W;
  localparam int RW   = dsip_pkg::RADIUS_W;
  localparam int SW   = dsip_pkg::SQ_W;
  localparam int DW   = dsip_pkg::D2_W;

  // Disk store.
  logic [CEN_W-1:0] center_mem [MAX_DISKS];
  logic [RW-1:0]    radius_mem [MAX_DISKS];

  // Item and set state.
  dsip_pkg::dsip_in_t         item_r;
  logic [CW-1:0]              count_r;
  logic                       empty_r;
  logic [dsip_pkg::LABEL_W-1:0] label_r;
  logic                       ovf_r;

  // Walk counters and pipeline.
  logic [CW-1:0]    rd_r, wr_r, rd_inc;
  logic             stop_r;
  logic             v1_r, v2_r;
  logic [CEN_W-1:0] c1_r, c2_r;
  logic [RW-1:0]    r1_r, r2_r;
  logic [SW-1:0]    sq_r [MAX_DIM];
  logic [DW-1:0]    sum2_r;
  logic [SW-1:0]    diff2_r;
  logic             ge_r;

  // Result register.
  logic                out_valid_r;
  dsip_pkg::dsip_out_t out_data_r;

  logic                       full;
  logic [dsip_pkg::DIM_W-1:0] dims;
  logic signed [dsip_pkg::COORD_W-1:0] coord_in [dsip_pkg::NUM_COORDS];
  logic [DW-1:0]              d2;
  logic                       overlap, contained, keep;
  logic                       app_we;

  assign full   = (count_r == CW'(MAX_DISKS));
  assign rd_inc = rd_r + CW'(1);
  assign dims   = (dimension > dsip_pkg::DIM_W'(MAX_DIM)) ?
                  dsip_pkg::DIM_W'(MAX_DIM) : dimension;
  assign app_we = cmd.exec && (item_r.mode == dsip_pkg::MODE_APPEND) && !full;

  assign coord_in[0] = item_r.coord_0;
  assign coord_in[1] = item_r.coord_1;
  assign coord_in[2] = item_r.coord_2;
  assign coord_in[3] = item_r.coord_3;

  // Status to the controller.
  assign sts.walk_req   = (in_data.mode == dsip_pkg::MODE_UPDATE) && (count_r != '0);
  assign sts.last_issue = (rd_inc == count_r);
  assign sts.pipe_empty = !v1_r && !v2_r;
  assign sts.out_free   = !out_valid_r || out_ready;

  // Store writes: an append at the end of the set, or a kept entry during a walk.
  always_ff @(posedge clk) begin
    if (app_we) begin
      for (int k = 0; k < MAX_DIM; k++) begin
        center_mem[count_r[AW-1:0]][k*dsip_pkg::COORD_W +: dsip_pkg::COORD_W] <= coord_in[k];
      end
      radius_mem[count_r[AW-1:0]] <= item_r.radius;
    end else if (keep) begin
      center_mem[wr_r[AW-1:0]] <= c2_r;
      radius_mem[wr_r[AW-1:0]] <= r2_r;
    end
  end

  // Registered store read.
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      c1_r <= center_mem[rd_r[AW-1:0]];
      r1_r <= radius_mem[rd_r[AW-1:0]];
    end
  end

  // Item capture.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_r <= in_data;
    end
  end

  // Stage one: per-coordinate squared differences and the radius bounds.
  always_ff @(posedge clk) begin
    logic signed [dsip_pkg::COORD_W:0]     dk;
    logic signed [2*dsip_pkg::COORD_W+1:0] prod;
    logic [RW:0]                           rsum;
    logic [RW-1:0]                         rdiff;
    for (int k = 0; k < MAX_DIM; k++) begin
      dk   = $signed({coord_in[k][dsip_pkg::COORD_W-1], coord_in[k]})
           - $signed({c1_r[k*dsip_pkg::COORD_W + dsip_pkg::COORD_W - 1],
                      c1_r[k*dsip_pkg::COORD_W +: dsip_pkg::COORD_W]});
      prod = dk * dk;
      sq_r[k] <= (dsip_pkg::DIM_W'(k) < dims) ? prod[SW-1:0] : '0;
    end
    rsum    = {1'b0, r1_r} + {1'b0, item_r.radius};
    rdiff   = r1_r - item_r.radius;
    sum2_r  <= rsum * rsum;
    diff2_r <= rdiff * rdiff;
    ge_r    <= (r1_r >= item_r.radius);
    c2_r    <= c1_r;
    r2_r    <= r1_r;
  end

  // Stage two: total squared distance and the keep / stop decision.
  always_comb begin
    d2 = '0;
    for (int k = 0; k < MAX_DIM; k++) begin
      d2 = d2 + DW'(sq_r[k]);
    end
    overlap   = (d2 < sum2_r);
    contained = ge_r && (d2 <= DW'(diff2_r));
    keep      = v2_r && (stop_r || overlap);
  end

  // Pipeline valid bits and walk counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      rd_r   <= '0;
      wr_r   <= '0;
      stop_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
      if (cmd.latch) begin
        rd_r   <= '0;
        wr_r   <= '0;
        stop_r <= 1'b0;
      end else begin
        if (cmd.issue) begin
          rd_r <= rd_inc;
        end
        if (keep) begin
          wr_r <= wr_r + CW'(1);
        end
        if (v2_r && !stop_r && overlap && contained) begin
          stop_r <= 1'b1;
        end
      end
    end
  end

  // Set state: count, empty flag, label and overflow.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      empty_r <= 1'b0;
      label_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      if (cmd.latch) begin
        ovf_r <= 1'b0;
      end
      if (v2_r && !stop_r && overlap && contained) begin
        empty_r <= 1'b1;
      end
      if (cmd.commit) begin
        count_r <= wr_r;
      end
      if (cmd.exec) begin
        case (item_r.mode)
          dsip_pkg::MODE_INIT: begin
            label_r <= item_r.label;
            empty_r <= 1'b0;
            count_r <= '0;
          end
          dsip_pkg::MODE_APPEND: begin
            if (full) begin
              ovf_r <= 1'b1;
            end else begin
              count_r <= count_r + CW'(1);
            end
          end
          dsip_pkg::MODE_CLEAN: begin
            count_r <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Result register: holds a beat until the receiver takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r.is_empty     <= empty_r;
      out_data_r.disk_count   <= dsip_pkg::COUNT_OUT_W'(count_r);
      out_data_r.stored_label <= label_r;
      out_data_r.overflow     <= ovf_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A kept entry is always written below the entry being read next.
  a_wr_behind_rd: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> (wr_r < rd_r))
    else $error("walk write pointer caught up with read pointer");

  // The set never holds more disks than the store has room for.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_DISKS))
    else $error("disk count beyond store depth");

  // Simple operations and the commit of a walk only happen while the compare pipeline is empty.
  a_exec_idle_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec || cmd.commit) |-> (!v1_r && !v2_r))
    else $error("set update while the compare pipeline is busy");

  // A new result is only loaded into a free result register.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result overwritten before it was taken");

endmodule

`default_nettype wire
